>>> rtl/core/lpxfc_pkg.sv
// shared constants and beat types for the length-prefixed xor frame checker
// no dependencies; used by every module in rtl/core
package lpxfc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65536;
    localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned HDR_BYTES       = 4;
    localparam int unsigned MIN_FRAME       = 5;

    localparam logic [2:0] STATUS_BUSY      = 3'd0;
    localparam logic [2:0] STATUS_OK        = 3'd1;
    localparam logic [2:0] STATUS_SHORT     = 3'd2;
    localparam logic [2:0] STATUS_MISMATCH  = 3'd3;
    localparam logic [2:0] STATUS_CSUM_FAIL = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  payload_out;
        logic        payload_strobe;
        logic [2:0]  frame_status;
        logic [31:0] header_length;
    } out_beat_t;

endpackage

>>> rtl/core/lpxfc_in_stage.sv
// input register stage: captures one received beat, frees when the core takes it
// depends on lpxfc_pkg
module lpxfc_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    output logic                 beat_valid,
    input  logic                 beat_take,
    output lpxfc_pkg::in_beat_t  beat
);

    logic                valid_reg;
    logic                valid_next;
    lpxfc_pkg::in_beat_t beat_reg;

    assign in_ready   = !valid_reg || beat_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (beat_take ? 1'b0 : valid_reg);
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg.rx_byte   <= rx_byte;
            beat_reg.frame_end <= frame_end;
        end
    end

endmodule

>>> rtl/core/lpxfc_frame_logic.sv
// frame state (position, header shift, running xor) and result register
// depends on lpxfc_pkg
module lpxfc_frame_logic
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat_valid,
    output logic                 beat_take,
    input  lpxfc_pkg::in_beat_t  beat,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lpxfc_pkg::out_beat_t res
);

    localparam int unsigned PW = lpxfc_pkg::POS_W;

    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        pos_next;
    logic [31:0]          len_reg;
    logic [31:0]          len_next;
    logic [7:0]           xor_reg;
    logic [7:0]           xor_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    lpxfc_pkg::out_beat_t res_reg;
    lpxfc_pkg::out_beat_t res_next;

    logic        in_hdr;
    logic [31:0] hdr;
    logic [32:0] count;
    logic        strobe;
    logic        over;
    logic [2:0]  status;

    assign beat_take = beat_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        in_hdr = pos_reg < PW'(lpxfc_pkg::HDR_BYTES);
        hdr    = in_hdr ? {len_reg[23:0], beat.rx_byte} : len_reg;
        count  = 33'(pos_reg) + 33'd1;
        strobe = !beat.frame_end && !in_hdr && (count < {1'b0, hdr});
        over   = pos_reg >= PW'(lpxfc_pkg::MAX_FRAME_BYTES);

        status = lpxfc_pkg::STATUS_BUSY;
        if (beat.frame_end)
        begin
            if (!over && count < 33'(lpxfc_pkg::MIN_FRAME))
                status = lpxfc_pkg::STATUS_SHORT;
            else if (over || count != {1'b0, hdr})
                status = lpxfc_pkg::STATUS_MISMATCH;
            else if (beat.rx_byte != xor_reg)
                status = lpxfc_pkg::STATUS_CSUM_FAIL;
            else
                status = lpxfc_pkg::STATUS_OK;
        end

        // final byte clears all frame state
        if (beat.frame_end)
        begin
            pos_next = '0;
            len_next = '0;
            xor_next = '0;
        end
        else
        begin
            pos_next = over ? pos_reg : pos_reg + PW'(1);
            len_next = hdr;
            xor_next = strobe ? (xor_reg ^ beat.rx_byte) : xor_reg;
        end

        res_next.payload_out    = strobe ? beat.rx_byte : 8'd0;
        res_next.payload_strobe = strobe;
        res_next.frame_status   = status;
        res_next.header_length  = hdr;

        res_valid_next = beat_take ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            xor_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (beat_take)
            begin
                pos_reg <= pos_next;
                len_reg <= len_next;
                xor_reg <= xor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/core/length_prefixed_xor_frame_checker_unit.sv
// an accepted input beat waits in the input register; its result beat is valid once it moves into the result register
// throughput: one beat per cycle while out_ready is high; set by the single input register and result register
// in_ready is high while the input register is empty or its beat moves into a free or
// draining result register
// reset (rst_n low, asynchronous) empties both registers and clears the frame state
// top level of the frame checker; depends on lpxfc_pkg, lpxfc_in_stage, lpxfc_frame_logic
module length_prefixed_xor_frame_checker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_out,
    output logic        payload_strobe,
    output logic [2:0]  frame_status,
    output logic [31:0] header_length
);

    logic                 beat_valid;
    logic                 beat_take;
    lpxfc_pkg::in_beat_t  beat;
    lpxfc_pkg::out_beat_t res;

    lpxfc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .frame_end  (frame_end),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .beat       (beat)
    );

    lpxfc_frame_logic u_frame_logic
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .beat       (beat),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign payload_out    = res.payload_out;
    assign payload_strobe = res.payload_strobe;
    assign frame_status   = res.frame_status;
    assign header_length  = res.header_length;

endmodule

>>> test/tb_length_prefixed_xor_frame_checker_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for length_prefixed_xor_frame_checker_unit
// depends on lpxfc_pkg and the checker rtl; runs directed, large-header and random frames
module tb_length_prefixed_xor_frame_checker_unit;

    localparam int unsigned RANDOM_BEATS = 1850;
    localparam longint unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  payload_out;
    logic        payload_strobe;
    logic [2:0]  frame_status;
    logic [31:0] header_length;

    // frame tracking state of the predictor
    logic [lpxfc_pkg::POS_W-1:0] frame_pos = '0;
    logic [31:0]                 hdr_shift = '0;
    logic [7:0]                  run_xor = '0;

    lpxfc_pkg::out_beat_t awaited_beats[$];
    int unsigned          mismatches = 0;
    int unsigned          beats_sent = 0;
    int unsigned          frames_sent = 0;
    int unsigned          status_seen[0:4] = '{default: 0};
    longint unsigned      cycles = 0;
    bit                   in_idle_on = 1'b0;
    bit                   out_idle_on = 1'b0;
    int unsigned          stall_left = 0;

    length_prefixed_xor_frame_checker_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_out    (payload_out),
        .payload_strobe (payload_strobe),
        .frame_status   (frame_status),
        .header_length  (header_length)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still awaited",
                     cycles, awaited_beats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // advance the frame state by one byte and return the beat the block should produce
    function automatic lpxfc_pkg::out_beat_t track_frame_byte(input logic [7:0] b,
                                                              input logic last);
        lpxfc_pkg::out_beat_t        r;
        logic [lpxfc_pkg::POS_W-1:0] p;
        logic                        over;
        longint unsigned             cnt;
        p = frame_pos;
        r = '0;
        if (p < lpxfc_pkg::HDR_BYTES)
            hdr_shift = {hdr_shift[23:0], b};
        r.header_length = hdr_shift;
        r.frame_status = lpxfc_pkg::STATUS_BUSY;
        if (!last && p >= lpxfc_pkg::HDR_BYTES && (64'(p) + 64'd1) < 64'(hdr_shift))
        begin
            r.payload_strobe = 1'b1;
            r.payload_out = b;
            run_xor = run_xor ^ b;
        end
        if (last)
        begin
            over = (p >= lpxfc_pkg::MAX_FRAME_BYTES);
            cnt = 64'(p) + 64'd1;
            if (!over && cnt < lpxfc_pkg::MIN_FRAME)
                r.frame_status = lpxfc_pkg::STATUS_SHORT;
            else if (over || cnt != 64'(hdr_shift))
                r.frame_status = lpxfc_pkg::STATUS_MISMATCH;
            else if (b != run_xor)
                r.frame_status = lpxfc_pkg::STATUS_CSUM_FAIL;
            else
                r.frame_status = lpxfc_pkg::STATUS_OK;
            frame_pos = '0;
            hdr_shift = '0;
            run_xor = '0;
        end
        else if (p < lpxfc_pkg::MAX_FRAME_BYTES)
        begin
            frame_pos = p + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                     what, got, want, cycles);
    endtask

    // result side: compare every accepted beat with the oldest prediction
    always @(posedge clk)
    begin
        lpxfc_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_beats.size() == 0)
            begin
                report_mismatch("unexpected result beat", {29'b0, frame_status}, 32'h0);
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (payload_out !== want.payload_out)
                    report_mismatch("payload_out", 32'(payload_out),
                                    32'(want.payload_out));
                if (payload_strobe !== want.payload_strobe)
                    report_mismatch("payload_strobe", 32'(payload_strobe),
                                    32'(want.payload_strobe));
                if (frame_status !== want.frame_status)
                    report_mismatch("frame_status", 32'(frame_status),
                                    32'(want.frame_status));
                if (header_length !== want.header_length)
                    report_mismatch("header_length", header_length, want.header_length);
                if (want.frame_status <= lpxfc_pkg::STATUS_CSUM_FAIL)
                    status_seen[want.frame_status]++;
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (out_idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = idle_len() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // called in step with the clock; returns once the block has taken the beat
    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = (in_idle_on && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_end <= last;
        awaited_beats.push_back(track_frame_byte(b, last));
        beats_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // header taken from declared, payload random, final byte (if past the header) the xor or a corrupted xor
    task automatic send_frame(input logic [31:0] declared, input int unsigned nbytes,
                              input bit good_csum);
        logic [7:0]  csum;
        logic [7:0]  b;
        int unsigned p;
        int unsigned psat;
        csum = 8'h00;
        for (p = 0; p < nbytes; p++)
        begin
            psat = (p > lpxfc_pkg::MAX_FRAME_BYTES) ? lpxfc_pkg::MAX_FRAME_BYTES : p;
            if (p < lpxfc_pkg::HDR_BYTES)
                b = declared[(31 - 8 * p) -: 8];
            else if (p == nbytes - 1)
                b = good_csum ? csum : csum ^ 8'($urandom_range(1, 255));
            else
                b = 8'($urandom_range(0, 255));
            if (p >= lpxfc_pkg::HDR_BYTES && p != nbytes - 1
                && (64'(psat) + 64'd1) < 64'(declared))
                csum = csum ^ b;
            send_beat(b, p == nbytes - 1);
        end
        frames_sent++;
    endtask

    // random bytes with stray frame ends, always closed by a final beat
    task automatic send_noise();
        int unsigned n;
        int unsigned i;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++)
            send_beat(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 5) == 0));
        frames_sent++;
    endtask

    task automatic test_short_frames();
        send_frame(32'hFF00_0000, 1, 1'b1);
        send_frame(32'h0000_0005, 4, 1'b1);
    endtask

    task automatic test_status_codes();
        send_frame(32'd5, 5, 1'b1);
        send_frame(32'd6, 6, 1'b1);
        send_frame(32'd6, 6, 1'b0);
        send_frame(32'hFFFF_FFFF, 5, 1'b1);
    endtask

    // headers at and above the counter limit on short frames
    task automatic test_large_declared_lengths();
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        send_frame(lpxfc_pkg::MAX_FRAME_BYTES, 40, 1'b1);
        send_frame(32'd70000, 30, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned start_beats;
        int unsigned kind;
        int unsigned len;
        int unsigned decl;
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            in_idle_on = ($urandom_range(0, 9) != 0);
            out_idle_on = ($urandom_range(0, 9) != 0);
            kind = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300) : $urandom_range(5, 40);
            if (kind < 60)
            begin
                send_frame(len, len, $urandom_range(0, 4) != 0);
            end
            else if (kind < 72)
            begin
                decl = $urandom_range(0, 1) ? len + $urandom_range(1, 3)
                                            : len - $urandom_range(1, 3);
                send_frame(decl, len, 1'b1);
            end
            else if (kind < 82)
            begin
                send_frame($urandom(), $urandom_range(1, 4), 1'b1);
            end
            else if (kind < 92)
            begin
                send_frame($urandom(), $urandom_range(5, 24), $urandom_range(0, 1) == 1);
            end
            else
            begin
                send_noise();
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_frames();
        test_status_codes();
        test_large_declared_lengths();
        test_random_traffic();
        in_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d byte beats in %0d frames, %0d cycles", beats_sent, frames_sent, cycles);
        $display("final statuses: %0d ok, %0d short, %0d length mismatch, %0d checksum fail",
                 status_seen[lpxfc_pkg::STATUS_OK], status_seen[lpxfc_pkg::STATUS_SHORT],
                 status_seen[lpxfc_pkg::STATUS_MISMATCH],
                 status_seen[lpxfc_pkg::STATUS_CSUM_FAIL]);
        if (mismatches == 0 && awaited_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lpxfc_pkg.sv
rtl/core/lpxfc_in_stage.sv
rtl/core/lpxfc_frame_logic.sv
rtl/core/length_prefixed_xor_frame_checker_unit.sv
test/tb_length_prefixed_xor_frame_checker_unit.sv
